[rtl/adaptive_traffic_green_selector_unit_defines.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the traffic green selector
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ADAPTIVE_TRAFFIC_GREEN_SELECTOR_UNIT_DEFINES_SVH
`define ADAPTIVE_TRAFFIC_GREEN_SELECTOR_UNIT_DEFINES_SVH

// Check that a condition holds in the same cycle as its trigger
`define ATGS_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// Check that a condition holds in the cycle after its trigger
`define ATGS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

[rtl/atgs_pkg.sv]
// ----------------------------------------------------------------------------
// atgs_pkg
// Shared constants, types and the seven-segment decode of the green selector.
// ----------------------------------------------------------------------------
package atgs_pkg;

    localparam int NUM_ROADS     = 4;
    localparam int ROAD_W        = $clog2(NUM_ROADS);
    localparam int COUNT_MAX_DEF = 255;

    localparam int SEG_W         = 7;
    localparam int SERVED_W      = 8;
    localparam int UNITS_W       = 8;
    localparam int TICKS_W       = 32;
    localparam int CFG_IDX_W     = 1;

    localparam logic [TICKS_W-1:0] TICKS_PER_UNIT_RESET = 32'd100_000_000;
    localparam logic [UNITS_W-1:0] DEFAULT_UNITS_RESET  = 8'd5;
    localparam logic [UNITS_W-1:0] PERIOD_UNITS_RESET   = 8'd5;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TICKS_PER_UNIT = 1'b0,
        CFG_DEFAULT_UNITS  = 1'b1
    } cfg_reg_t;

    // Lamp and display state handed from the road logic to the result port
    typedef struct packed {
        logic [ROAD_W-1:0] green_road;
        logic              green_on;
        logic [ROAD_W-1:0] display_road;
        logic [SEG_W-1:0]  display_segments;
    } atgs_view_t;

    // Seven-segment pattern of one decimal digit, bit 0 is segment a
    function automatic logic [SEG_W-1:0] seg_code(input logic [3:0] digit);
        logic [SEG_W-1:0] code;
        case (digit)
            4'd0:    code = 7'h3F;
            4'd1:    code = 7'h06;
            4'd2:    code = 7'h5B;
            4'd3:    code = 7'h4F;
            4'd4:    code = 7'h66;
            4'd5:    code = 7'h6D;
            4'd6:    code = 7'h7D;
            4'd7:    code = 7'h07;
            4'd8:    code = 7'h7F;
            4'd9:    code = 7'h6F;
            default: code = 7'h00;
        endcase
        return code;
    endfunction

endpackage

[rtl/atgs_channels.sv]
// ----------------------------------------------------------------------------
// atgs channels
// Valid/ready channels for sensor samples, results and configuration writes.
// ----------------------------------------------------------------------------

// Sensor sample channel
interface atgs_sample_if;
    logic                             valid;
    logic                             ready;
    logic [atgs_pkg::NUM_ROADS-1:0]   sensors;

    modport source (output valid, output sensors, input ready);
    modport sink   (input valid, input sensors, output ready);
endinterface

// Result channel
interface atgs_result_if;
    logic                             valid;
    logic                             ready;
    logic [atgs_pkg::ROAD_W-1:0]      green_road;
    logic                             green_on;
    logic [atgs_pkg::ROAD_W-1:0]      display_road;
    logic [atgs_pkg::SEG_W-1:0]       display_segments;
    logic                             period_end;
    logic [atgs_pkg::SERVED_W-1:0]    served_count;

    modport source (output valid, output green_road, output green_on, output display_road,
                    output display_segments, output period_end, output served_count,
                    input ready);
    modport sink   (input valid, input green_road, input green_on, input display_road,
                    input display_segments, input period_end, input served_count,
                    output ready);
endinterface

// Configuration write channel
interface atgs_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [atgs_pkg::CFG_IDX_W-1:0]   index;
    logic [atgs_pkg::TICKS_W-1:0]     data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

[rtl/atgs_roads.sv]
// ----------------------------------------------------------------------------
// atgs_roads
// Per-road edge counting, display update and greatest-demand road choice.
// ----------------------------------------------------------------------------
module atgs_roads #(
    parameter int COUNT_MAX = atgs_pkg::COUNT_MAX_DEF,
    parameter int CNT_W     = $clog2(COUNT_MAX + 1)
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             step,
    input  logic [atgs_pkg::NUM_ROADS-1:0]   sensors,
    input  logic                             period_end,
    output logic [CNT_W-1:0]                 served,
    output atgs_pkg::atgs_view_t             view
);

    localparam logic [CNT_W-1:0] CNT_LIMIT = CNT_W'(COUNT_MAX);

    logic [atgs_pkg::NUM_ROADS-1:0] prev_reg;
    logic [CNT_W-1:0]               cnt_reg  [atgs_pkg::NUM_ROADS];
    logic [CNT_W-1:0]               cnt_next [atgs_pkg::NUM_ROADS];
    logic [CNT_W-1:0]               cnt_up   [atgs_pkg::NUM_ROADS];
    logic [3:0]                     dig_reg  [atgs_pkg::NUM_ROADS];
    logic [3:0]                     dig_next [atgs_pkg::NUM_ROADS];
    logic [3:0]                     dig_up   [atgs_pkg::NUM_ROADS];
    logic [atgs_pkg::NUM_ROADS-1:0] rising;
    logic [CNT_W-1:0]               best;
    logic [atgs_pkg::ROAD_W-1:0]    best_road;
    atgs_pkg::atgs_view_t           view_reg;
    atgs_pkg::atgs_view_t           view_next;

    assign rising = sensors & ~prev_reg;

    // Count rising edges; keep a decimal digit alongside each count
    always_comb
    begin
        for (int r = 0; r < atgs_pkg::NUM_ROADS; r++)
        begin
            if (rising[r] && (cnt_reg[r] != CNT_LIMIT))
            begin
                cnt_up[r] = cnt_reg[r] + CNT_W'(1);
                dig_up[r] = (dig_reg[r] == 4'd9) ? 4'd0 : dig_reg[r] + 4'd1;
            end
            else
            begin
                cnt_up[r] = cnt_reg[r];
                dig_up[r] = dig_reg[r];
            end
        end
    end

    // Pick the strictly greatest count, first road on ties
    always_comb
    begin
        best      = '0;
        best_road = '0;
        for (int r = 0; r < atgs_pkg::NUM_ROADS; r++)
        begin
            if (cnt_up[r] > best)
            begin
                best      = cnt_up[r];
                best_road = atgs_pkg::ROAD_W'(r);
            end
        end
    end

    assign served = best;

    // Clear the served road and update lamps and display
    always_comb
    begin
        view_next = view_reg;
        for (int r = 0; r < atgs_pkg::NUM_ROADS; r++)
        begin
            if (period_end && (best_road == atgs_pkg::ROAD_W'(r)))
            begin
                cnt_next[r] = '0;
                dig_next[r] = 4'd0;
            end
            else
            begin
                cnt_next[r] = cnt_up[r];
                dig_next[r] = dig_up[r];
            end
            if (rising[r])
            begin
                view_next.display_road     = atgs_pkg::ROAD_W'(r);
                view_next.display_segments = atgs_pkg::seg_code(dig_up[r]);
            end
        end
        if (period_end)
        begin
            view_next.green_road = best_road;
            view_next.green_on   = 1'b1;
        end
    end

    // Advance road state on each processed sample
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_reg <= '1;
            view_reg <= '0;
            for (int r = 0; r < atgs_pkg::NUM_ROADS; r++)
            begin
                cnt_reg[r] <= '0;
                dig_reg[r] <= 4'd0;
            end
        end
        else if (step)
        begin
            prev_reg <= sensors;
            view_reg <= view_next;
            for (int r = 0; r < atgs_pkg::NUM_ROADS; r++)
            begin
                cnt_reg[r] <= cnt_next[r];
                dig_reg[r] <= dig_next[r];
            end
        end
    end

    assign view = view_reg;

endmodule

[rtl/atgs_timer.sv]
// ----------------------------------------------------------------------------
// atgs_timer
// Configuration registers and the nested tick/unit timer of the green period.
// ----------------------------------------------------------------------------
module atgs_timer #(
    parameter int CNT_W = 8
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             step,
    input  logic                             cfg_we,
    input  logic [atgs_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [atgs_pkg::TICKS_W-1:0]     cfg_data,
    input  logic [CNT_W-1:0]                 served,
    output logic                             period_end
);

    localparam int EXT_W = (CNT_W > atgs_pkg::UNITS_W) ? CNT_W : atgs_pkg::UNITS_W;

    logic [atgs_pkg::TICKS_W-1:0] tpu_reg;
    logic [atgs_pkg::UNITS_W-1:0] def_reg;
    logic [atgs_pkg::TICKS_W-1:0] tick_reg;
    logic [atgs_pkg::TICKS_W-1:0] tick_next;
    logic [atgs_pkg::UNITS_W-1:0] elapsed_reg;
    logic [atgs_pkg::UNITS_W-1:0] elapsed_next;
    logic [atgs_pkg::UNITS_W-1:0] units_reg;
    logic [atgs_pkg::UNITS_W-1:0] units_next;
    logic [atgs_pkg::TICKS_W-1:0] tpu_eff;
    logic [atgs_pkg::UNITS_W-1:0] def_eff;
    logic [atgs_pkg::TICKS_W-1:0] tick_inc;
    logic [atgs_pkg::UNITS_W-1:0] elapsed_inc;
    logic                         unit_done;
    logic [EXT_W-1:0]             served_ext;
    logic [atgs_pkg::UNITS_W-1:0] served_sat;

    // Zero settings behave as one
    assign tpu_eff = (tpu_reg == '0) ? atgs_pkg::TICKS_W'(1) : tpu_reg;
    assign def_eff = (def_reg == '0) ? atgs_pkg::UNITS_W'(1) : def_reg;

    assign tick_inc    = tick_reg + atgs_pkg::TICKS_W'(1);
    assign unit_done   = (tick_inc >= tpu_eff);
    assign elapsed_inc = (elapsed_reg != '1) ? elapsed_reg + atgs_pkg::UNITS_W'(1)
                                             : elapsed_reg;
    assign period_end  = unit_done && (elapsed_inc >= units_reg);

    // Saturate the served count into a period length
    assign served_ext = EXT_W'(served);
    assign served_sat = (served_ext > EXT_W'({atgs_pkg::UNITS_W{1'b1}}))
                        ? '1 : served_ext[atgs_pkg::UNITS_W-1:0];

    always_comb
    begin
        tick_next    = unit_done ? '0 : tick_inc;
        elapsed_next = elapsed_reg;
        units_next   = units_reg;
        if (period_end)
        begin
            elapsed_next = '0;
            units_next   = (served == '0) ? def_eff : served_sat;
        end
        else if (unit_done)
        begin
            elapsed_next = elapsed_inc;
        end
    end

    // Hold configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tpu_reg <= atgs_pkg::TICKS_PER_UNIT_RESET;
            def_reg <= atgs_pkg::DEFAULT_UNITS_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                atgs_pkg::CFG_TICKS_PER_UNIT: tpu_reg <= cfg_data;
                atgs_pkg::CFG_DEFAULT_UNITS:  def_reg <= cfg_data[atgs_pkg::UNITS_W-1:0];
                default:                      tpu_reg <= tpu_reg;
            endcase
        end
    end

    // Advance the period timer on each processed sample
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_reg    <= '0;
            elapsed_reg <= '0;
            units_reg   <= atgs_pkg::PERIOD_UNITS_RESET;
        end
        else if (step)
        begin
            tick_reg    <= tick_next;
            elapsed_reg <= elapsed_next;
            units_reg   <= units_next;
        end
    end

endmodule

[rtl/adaptive_traffic_green_selector_unit.sv]
// ----------------------------------------------------------------------------
// adaptive_traffic_green_selector_unit
// Demand-adaptive traffic light controller: counts vehicles and picks green.
// ----------------------------------------------------------------------------
// Usage:
//   sample : one request per tick carrying the four road sensor levels.
//   result : one request back per sample with lamp, display and period-end
//            fields showing the state after that sample.
//   cfg    : register writes (index 0 ticks per unit, index 1 default units),
//            always ready; write only while no sample is in flight.
// Flow: an accepted sample enters the input register; its result is
//   registered into the result register when result is not held.
//   Throughput: one sample per cycle while result is not held, set by the
//   combinational update of counters, compare chain and timer in between.
// Reset: counters and display clear, no green lamp lit, period length 5 units
//   of 100000000 ticks, previous sensor sample taken as all ones.
// Stall: while result is held, the input register keeps one more sample;
//   sample ready drops only when both the input and result registers are full.
// ----------------------------------------------------------------------------
`include "adaptive_traffic_green_selector_unit_defines.svh"

module adaptive_traffic_green_selector_unit #(
    parameter int COUNT_MAX = atgs_pkg::COUNT_MAX_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    atgs_sample_if.sink    sample,
    atgs_result_if.source  result,
    atgs_cfg_if.sink       cfg
);

    localparam int CNT_W = $clog2(COUNT_MAX + 1);
    localparam int EXT_W = (CNT_W > atgs_pkg::SERVED_W) ? CNT_W : atgs_pkg::SERVED_W;

    logic                            s1_valid_reg;
    logic                            s1_valid_next;
    logic [atgs_pkg::NUM_ROADS-1:0]  s1_sensors_reg;
    logic                            out_valid_reg;
    logic                            out_valid_next;
    logic                            end_reg;
    logic                            end_next;
    logic [atgs_pkg::SERVED_W-1:0]   served_reg;
    logic [atgs_pkg::SERVED_W-1:0]   served_next;
    logic                            adv;
    logic                            step;
    logic                            period_end;
    logic [CNT_W-1:0]                served;
    logic [EXT_W-1:0]                served_ext;
    atgs_pkg::atgs_view_t            view;

    // Handshake control
    assign adv          = !out_valid_reg || result.ready;
    assign step         = s1_valid_reg && adv;
    assign sample.ready = !s1_valid_reg || adv;
    assign cfg.ready    = 1'b1;

    atgs_roads #(
        .COUNT_MAX (COUNT_MAX),
        .CNT_W     (CNT_W)
    ) u_roads (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (step),
        .sensors    (s1_sensors_reg),
        .period_end (period_end),
        .served     (served),
        .view       (view)
    );

    atgs_timer #(
        .CNT_W (CNT_W)
    ) u_timer (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (step),
        .cfg_we     (cfg.valid),
        .cfg_index  (cfg.index),
        .cfg_data   (cfg.data),
        .served     (served),
        .period_end (period_end)
    );

    assign served_ext = EXT_W'(served);

    always_comb
    begin
        s1_valid_next  = sample.ready ? sample.valid : s1_valid_reg;
        out_valid_next = adv ? s1_valid_reg : out_valid_reg;
        end_next       = end_reg;
        served_next    = served_reg;
        if (step)
        begin
            end_next    = period_end;
            served_next = period_end ? served_ext[atgs_pkg::SERVED_W-1:0] : '0;
        end
    end

    // Hold the valid flags of the input and result registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Capture sample and result payload
    always_ff @(posedge clk)
    begin
        if (sample.ready)
        begin
            s1_sensors_reg <= sample.sensors;
        end
        end_reg    <= end_next;
        served_reg <= served_next;
    end

    assign result.valid            = out_valid_reg;
    assign result.green_road       = view.green_road;
    assign result.green_on         = view.green_on;
    assign result.display_road     = view.display_road;
    assign result.display_segments = view.display_segments;
    assign result.period_end       = end_reg;
    assign result.served_count     = served_reg;

    `ATGS_ASSERT_NOW(a_served_only_at_end, result.valid && !result.period_end, result.served_count == '0)
    `ATGS_ASSERT_NOW(a_green_after_end, result.valid && result.period_end, result.green_on)
    `ATGS_ASSERT_NEXT(a_input_holds_on_stall, s1_valid_reg && !adv, s1_valid_reg)

endmodule
